>>> rtl/core/pn2_pkg.sv
// Shared types and constants for the 2-D gradient noise core.
package pn2_pkg;

  localparam int GRID_DIM   = 64;
  localparam int GRID_BITS  = $clog2(GRID_DIM);
  localparam int FRAC_BITS  = 10;
  localparam int COORD_BITS = 16;
  localparam int BANKS      = 4;
  localparam int BANK_AW    = 2 * (GRID_BITS - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);
  localparam int PIPE_LEN   = 9;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic                            is_query;
    logic [1:0]                      wsel;
    logic [BANK_AW-1:0]              waddr;
    logic [31:0]                     wdata;
    logic [BANKS-1:0][BANK_AW-1:0]   raddr;
    logic [FRAC_BITS-1:0]            tx;
    logic [FRAC_BITS-1:0]            ty;
    logic                            px;
    logic                            py;
  } cmd_t;

endpackage

>>> rtl/core/perlin_noise_2d_core.sv
// Top level of the 2-D gradient noise core with quintic fade.
// Takes one item per cycle while busy is low: a load writes one gradient into the 64x64
// table, a query returns one saturated Q1.14 noise value after passing through the
// queue, the registered banked table read and then the fade and blend pipeline. The
// table is split into four banks by corner parity, so all four corners are read
// together and queries stream at one per cycle; a load may be followed by a query that
// reads it in the very next cycle. Results appear for one cycle under done and cannot be
// held off; busy rises only if the command queue fills. Table entries read before
// they are written return arbitrary values.
module perlin_noise_2d_core import pn2_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               kind,
  input  logic [5:0]         cell_col,
  input  logic [5:0]         cell_row,
  input  logic signed [15:0] grad_x,
  input  logic signed [15:0] grad_y,
  input  logic [15:0]        coord_x,
  input  logic [15:0]        coord_y,
  output logic               done,
  output logic signed [15:0] noise
);

  cmd_t f_cmd, q_cmd;
  logic q_full, q_empty, push, pop;

  assign busy = q_full;
  assign push = start && !busy;
  assign pop  = !q_empty;

  pn2_front u_front (
    .kind(kind), .cell_col(cell_col), .cell_row(cell_row),
    .grad_x(grad_x), .grad_y(grad_y), .coord_x(coord_x), .coord_y(coord_y),
    .cmd(f_cmd)
  );

  pn2_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .din(f_cmd), .pop(pop),
    .dout(q_cmd), .full(q_full), .empty(q_empty)
  );

  pn2_back u_back (
    .clk(clk), .rst(rst), .cv(pop), .cmd(q_cmd), .done(done), .noise(noise)
  );

  a_done_follows_query: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(pop && q_cmd.is_query, PIPE_LEN))
    else $error("result without a matching query");

  a_noise_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (noise <= 16'sd16384 && noise >= -16'sd16384))
    else $error("noise out of range");

  a_idle_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (!busy && !done))
    else $error("busy or done right after reset");

endmodule

>>> rtl/core/pn2_front.sv
// Front end: classifies an item and maps its corners onto the four table banks.
module pn2_front import pn2_pkg::*; (
  input  logic        kind,
  input  logic [5:0]  cell_col,
  input  logic [5:0]  cell_row,
  input  logic [15:0] grad_x,
  input  logic [15:0] grad_y,
  input  logic [15:0] coord_x,
  input  logic [15:0] coord_y,
  output cmd_t        cmd
);

  logic [GRID_BITS-1:0] x0, x1, y0, y1;
  logic [GRID_BITS-1:0] col [BANKS];
  logic [GRID_BITS-1:0] row [BANKS];
  logic [GRID_BITS-1:0] lcol, lrow;

  assign x0   = coord_x[FRAC_BITS +: GRID_BITS];
  assign y0   = coord_y[FRAC_BITS +: GRID_BITS];
  assign x1   = GRID_BITS'(x0 + 1'b1);
  assign y1   = GRID_BITS'(y0 + 1'b1);
  assign lcol = GRID_BITS'(cell_col);
  assign lrow = GRID_BITS'(cell_row);

  always_comb begin
    cmd.is_query = (kind == KIND_QUERY);
    cmd.wsel     = {lrow[0], lcol[0]};
    cmd.waddr    = {lrow[GRID_BITS-1:1], lcol[GRID_BITS-1:1]};
    cmd.wdata    = {grad_y, grad_x};
    cmd.tx       = coord_x[FRAC_BITS-1:0];
    cmd.ty       = coord_y[FRAC_BITS-1:0];
    cmd.px       = x0[0];
    cmd.py       = y0[0];
    for (int b = 0; b < BANKS; b++) begin
      col[b] = (x0[0] == b[0]) ? x0 : x1;
      row[b] = (y0[0] == b[1]) ? y0 : y1;
      cmd.raddr[b] = {row[b][GRID_BITS-1:1], col[b][GRID_BITS-1:1]};
    end
  end

endmodule

>>> rtl/core/pn2_queue.sv
// Short command queue between front and back.
module pn2_queue import pn2_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output cmd_t dout,
  output logic full,
  output logic empty
);

  cmd_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wptr, rptr;
  logic [Q_AW:0]   count;

  assign full  = (count == (Q_AW+1)'(Q_DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= Q_AW'(wptr + 1'b1);
      if (pop)  rptr <= Q_AW'(rptr + 1'b1);
      count <= (Q_AW+1)'(count + (Q_AW+1)'(push) - (Q_AW+1)'(pop));
    end
  end

endmodule

>>> rtl/core/pn2_fade.sv
// Pipelined quintic fade weight, five register stages.
module pn2_fade import pn2_pkg::*; (
  input  logic                 clk,
  input  logic [FRAC_BITS-1:0] t,
  output logic [16:0]          w
);

  logic [15:0] n, n1, n2v;
  logic [31:0] nn;
  logic [36:0] p;
  logic [15:0] sq;
  logic [20:0] p16;
  logic [31:0] n3m;
  logic [16:0] n3;
  logic [37:0] prod;
  logic [21:0] wv;

  assign n   = {t, (16 - FRAC_BITS)'(0)};
  assign n3  = 17'((33'(n3m) + 33'd32768) >> 16);
  assign wv  = 22'((prod + 38'd32768) >> 16);

  always_ff @(posedge clk) begin
    nn   <= 32'(n) * 32'(n);
    n1   <= n;
    p    <= 37'(nn) * 37'd6 + (37'd10 << 32) - 37'({n1, 16'b0}) * 37'd15;
    sq   <= 16'((33'(nn) + 33'd32768) >> 16);
    n2v  <= n1;
    p16  <= 21'((p + 37'd32768) >> 16);
    n3m  <= 32'(sq) * 32'(n2v);
    prod <= 38'(n3) * 38'(p16);
    w    <= (wv > 22'd65536) ? 17'd65536 : 17'(wv);
  end

endmodule

>>> rtl/core/pn2_back.sv
// Back end: banked gradient table, corner dot products and the two blends.
module pn2_back import pn2_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cv,
  input  cmd_t               cmd,
  output logic               done,
  output logic signed [15:0] noise
);

  logic [31:0] rd [BANKS];
  logic [PIPE_LEN-1:1] v;
  logic [FRAC_BITS-1:0] tx1, ty1;
  logic px1, py1;
  logic [16:0] wx5, wy5, wy6, wy7;

  logic [31:0] g [4];
  logic signed [11:0] fx [4];
  logic signed [11:0] fy [4];
  logic signed [27:0] pxp [4];
  logic signed [27:0] pyp [4];
  logic signed [28:0] s [4];
  logic signed [18:0] dot3 [4];
  logic signed [18:0] dot4 [4];
  logic signed [18:0] dot5 [4];
  logic signed [37:0] mab, mcd;
  logic signed [18:0] a6, c6;
  logic signed [37:0] rab, rcd;
  logic signed [20:0] ab7, cd7, ab8;
  logic signed [39:0] mr;
  logic signed [39:0] rr;
  logic signed [22:0] r9;

  localparam logic signed [11:0] ONE = 12'sd1 <<< FRAC_BITS;

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [31:0] mem [BANK_DEPTH];
    always_ff @(posedge clk) begin
      if (cv && !cmd.is_query && cmd.wsel == 2'(b)) mem[cmd.waddr] <= cmd.wdata;
      if (cv && cmd.is_query) rd[b] <= mem[cmd.raddr[b]];
    end
  end

  pn2_fade u_fade_x (.clk(clk), .t(cmd.tx), .w(wx5));
  pn2_fade u_fade_y (.clk(clk), .t(cmd.ty), .w(wy5));

  always_comb begin
    g[0] = rd[{py1, px1}];
    g[1] = rd[{py1, ~px1}];
    g[2] = rd[{~py1, px1}];
    g[3] = rd[{~py1, ~px1}];
    fx[0] = $signed({2'b0, tx1});
    fx[2] = fx[0];
    fx[1] = 12'(fx[0] - ONE);
    fx[3] = fx[1];
    fy[0] = $signed({2'b0, ty1});
    fy[1] = fy[0];
    fy[2] = 12'(fy[0] - ONE);
    fy[3] = fy[2];
    for (int k = 0; k < 4; k++) begin
      s[k] = 29'(pxp[k]) + 29'(pyp[k]);
    end
    rab = (mab + 38'sd32768 - $signed({37'b0, mab[37]})) >>> 16;
    rcd = (mcd + 38'sd32768 - $signed({37'b0, mcd[37]})) >>> 16;
    rr  = (mr + 40'sd32768 - $signed({39'b0, mr[39]})) >>> 16;
  end

  always_ff @(posedge clk) begin
    tx1 <= cmd.tx;
    ty1 <= cmd.ty;
    px1 <= cmd.px;
    py1 <= cmd.py;
    for (int k = 0; k < 4; k++) begin
      pxp[k]  <= $signed(g[k][15:0]) * fx[k];
      pyp[k]  <= $signed(g[k][31:16]) * fy[k];
      dot3[k] <= 19'((s[k] + 29'sd512 - $signed({28'b0, s[k][28]})) >>> FRAC_BITS);
      dot4[k] <= dot3[k];
      dot5[k] <= dot4[k];
    end
    mab <= $signed({1'b0, wx5}) * 20'(dot5[1] - dot5[0]);
    mcd <= $signed({1'b0, wx5}) * 20'(dot5[3] - dot5[2]);
    a6  <= dot5[0];
    c6  <= dot5[2];
    wy6 <= wy5;
    ab7 <= 21'(a6 + 21'(rab));
    cd7 <= 21'(c6 + 21'(rcd));
    wy7 <= wy6;
    mr  <= $signed({1'b0, wy7}) * 22'(cd7 - ab7);
    ab8 <= ab7;
  end

  assign r9 = 23'(ab8 + 23'(rr));

  always_ff @(posedge clk) begin
    if (r9 > 23'sd16384)       noise <= 16'sd16384;
    else if (r9 < -23'sd16384) noise <= -16'sd16384;
    else                       noise <= 16'(r9);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= '0;
      done <= 1'b0;
    end else begin
      v    <= {v[PIPE_LEN-2:1], cv && cmd.is_query};
      done <= v[PIPE_LEN-1];
    end
  end

endmodule

>>> test/perlin_noise_2d_core_tb.sv
// Self-checking testbench for the 2-D gradient noise core: gradient loads and noise queries.
`timescale 1ns / 100ps
module perlin_noise_2d_core_tb;
  import pn2_pkg::*;

  typedef struct {
    logic               kind;
    logic [5:0]         col;
    logic [5:0]         row;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic [15:0]        cx;
    logic [15:0]        cy;
  } cmd_item_t;

  localparam int IDLE_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic kind = KIND_LOAD;
  logic [5:0] cell_col = '0;
  logic [5:0] cell_row = '0;
  logic signed [15:0] grad_x = '0;
  logic signed [15:0] grad_y = '0;
  logic [15:0] coord_x = '0;
  logic [15:0] coord_y = '0;
  logic done;
  logic signed [15:0] noise;

  cmd_item_t pending[$];
  logic signed [15:0] noise_expected[$];
  logic [31:0] grad_model[GRID_DIM*GRID_DIM];
  bit written[GRID_DIM*GRID_DIM];

  int mismatches = 0;
  int loads_sent = 0;
  int queries_sent = 0;
  int noise_checked = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;

  perlin_noise_2d_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .cell_col(cell_col), .cell_row(cell_row), .grad_x(grad_x), .grad_y(grad_y),
    .coord_x(coord_x), .coord_y(coord_y), .done(done), .noise(noise)
  );

  always #5 clk = ~clk;

  function automatic longint round_shift(longint v, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v < 0) return -((-v + half) >>> s);
    return (v + half) >>> s;
  endfunction

  function automatic longint fade_weight(bit [63:0] n);
    bit [63:0] p, p16, n2, n3, w;
    p   = 6 * n * n + (64'd10 << 32) - 15 * (n << 16);
    p16 = (p + 32768) >> 16;
    n2  = (n * n + 32768) >> 16;
    n3  = (n2 * n + 32768) >> 16;
    w   = (n3 * p16 + 32768) >> 16;
    if (w > 65536) w = 65536;
    return longint'(w);
  endfunction

  function automatic longint corner_grad_dot(int col, int row, longint fx, longint fy);
    logic [31:0] e;
    longint gx, gy;
    e  = grad_model[row * GRID_DIM + col];
    gx = longint'($signed(e[15:0]));
    gy = longint'($signed(e[31:16]));
    return round_shift(gx * fx + gy * fy, FRAC_BITS);
  endfunction

  function automatic longint lerp_q16(longint a, longint b, longint w);
    return a + round_shift(w * (b - a), 16);
  endfunction

  function automatic logic signed [15:0] noise_at(logic [15:0] cx, logic [15:0] cy);
    longint tx, ty, one, ia, ib, ic, id, wx, wy, ab, cd, r;
    int x0, y0, x1, y1;
    tx  = cx & ((1 << FRAC_BITS) - 1);
    ty  = cy & ((1 << FRAC_BITS) - 1);
    x0  = (cx >> FRAC_BITS) % GRID_DIM;
    y0  = (cy >> FRAC_BITS) % GRID_DIM;
    x1  = (x0 + 1) % GRID_DIM;
    y1  = (y0 + 1) % GRID_DIM;
    one = longint'(1) << FRAC_BITS;
    ia  = corner_grad_dot(x0, y0, tx, ty);
    ib  = corner_grad_dot(x1, y0, tx - one, ty);
    ic  = corner_grad_dot(x0, y1, tx, ty - one);
    id  = corner_grad_dot(x1, y1, tx - one, ty - one);
    wx  = fade_weight(64'(tx) << (16 - FRAC_BITS));
    wy  = fade_weight(64'(ty) << (16 - FRAC_BITS));
    ab  = lerp_q16(ia, ib, wx);
    cd  = lerp_q16(ic, id, wx);
    r   = lerp_q16(ab, cd, wy);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return 16'(r);
  endfunction

  task automatic push_load(int col, int row, logic [15:0] gx, logic [15:0] gy);
    cmd_item_t it;
    it = '{KIND_LOAD, 6'(col), 6'(row), gx, gy, 16'($urandom), 16'($urandom)};
    written[(row % GRID_DIM) * GRID_DIM + (col % GRID_DIM)] = 1'b1;
    pending.push_back(it);
  endtask

  // load any unwritten corner first so every query reads defined entries
  task automatic push_query(logic [15:0] cx, logic [15:0] cy);
    cmd_item_t it;
    int x0, y0, cc, rr;
    x0 = (cx >> FRAC_BITS) % GRID_DIM;
    y0 = (cy >> FRAC_BITS) % GRID_DIM;
    for (int k = 0; k < 4; k++) begin
      cc = (x0 + k[0]) % GRID_DIM;
      rr = (y0 + k[1]) % GRID_DIM;
      if (!written[rr * GRID_DIM + cc])
        push_load(cc, rr, 16'($urandom_range(0, 32768) - 16384),
                  16'($urandom_range(0, 32768) - 16384));
    end
    it = '{KIND_QUERY, 6'($urandom), 6'($urandom), 16'($urandom), 16'($urandom), cx, cy};
    pending.push_back(it);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (pending[0].kind == KIND_LOAD) begin
          grad_model[pending[0].row * GRID_DIM + pending[0].col] =
            {pending[0].gy, pending[0].gx};
          loads_sent++;
        end else begin
          noise_expected.push_back(noise_at(pending[0].cx, pending[0].cy));
          queries_sent++;
        end
        void'(pending.pop_front());
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending.size() > 0) begin
        kind     <= pending[0].kind;
        cell_col <= pending[0].col;
        cell_row <= pending[0].row;
        grad_x   <= pending[0].gx;
        grad_y   <= pending[0].gy;
        coord_x  <= pending[0].cx;
        coord_y  <= pending[0].cy;
        start    <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (noise_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected noise transfer: %0d", noise);
      end else begin
        if (noise !== noise_expected[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("noise mismatch: expected %0d, got %0d", noise_expected[0], noise);
        end
        void'(noise_expected.pop_front());
        noise_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL perlin_noise_2d_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [15:0] extremes[4];
    extremes = '{16'h4000, 16'hC000, 16'h7FFF, 16'h8000};
    for (int k = 0; k < 4; k++) push_load(k[0], k[1], extremes[k], extremes[3 - k]);
    push_load(63, 63, 16'h4000, 16'h4000);
    push_load(0, 63, 16'hC000, 16'h4000);
    push_load(63, 0, 16'h8000, 16'h7FFF);
    push_query(16'h0000, 16'h0000);
    push_query(16'h0200, 16'h0200);
    push_query(16'h03FF, 16'h03FF);
    push_query(16'hFFFF, 16'hFFFF);
    push_query(16'hFC00, 16'h0000);
    push_query(16'h0000, 16'hFC00);
    push_query(16'hFC01, 16'hFFFF);
    push_query(16'h0001, 16'h0001);
    push_load(0, 0, 16'h3FFF, 16'hFFFF);
    push_query(16'h0000, 16'h0000);
    push_load(1, 0, 16'h0001, 16'hBFFF);
    push_query(16'h0155, 16'h02AA);
    while (pending.size() < 1900) begin
      if ($urandom_range(0, 9) < 3)
        push_load($urandom_range(0, 63), $urandom_range(0, 63), 16'($urandom),
                  16'($urandom));
      else if ($urandom_range(0, 4) == 0)
        push_query(16'($urandom) & 16'hFC00, 16'($urandom));
      else
        push_query(16'($urandom), 16'($urandom));
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (pending.size() > 0 || noise_expected.size() > 0 || start) @(posedge clk);
    repeat (3 * PIPE_LEN) @(posedge clk);
    $display("covered %0d gradient loads and %0d noise queries, %0d results checked",
             loads_sent, queries_sent, noise_checked);
    if (mismatches == 0 && noise_expected.size() == 0) begin
      $display("PASS perlin_noise_2d_core");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL perlin_noise_2d_core");
    end
    $finish;
  end

endmodule
